### src/twr_pkg.sv
// ----------------------------------------------------------------------------
// twr_pkg
// Shared types and constants for the wrapped-range AND/OR bound unit.
// ----------------------------------------------------------------------------
package twr_pkg;

   // default value width and fixed port field width
   localparam int unsigned WIDTH_DEFAULT = 8;
   localparam int unsigned FIELD_W       = 8;

   // result kind codes
   localparam logic [1:0] KIND_RANGE = 2'd0;
   localparam logic [1:0] KIND_EMPTY = 2'd1;
   localparam logic [1:0] KIND_FULL  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_MARK,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic mark;
      logic scan;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic mark_last;
   } status_type;

endpackage

### src/twr_ram.sv
// ----------------------------------------------------------------------------
// twr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module twr_ram #(
   parameter int unsigned DATA_W = 1,
   parameter int unsigned DEPTH  = 256
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [DATA_W-1:0]          wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [DATA_W-1:0]          rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/twr_ctrl.sv
// ----------------------------------------------------------------------------
// twr_ctrl
// Sequencer: clear sweep, pair marking, bitmap scan, finalize, hand off.
// ----------------------------------------------------------------------------
module twr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_is_empty,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output twr_pkg::cmd_type     cmd,
   input  twr_pkg::status_type  status
);
   import twr_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = req_is_empty ? ST_DONE : ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_MARK;
            end
         end
         ST_MARK: begin
            cmd.mark = 1'b1;
            if (status.mark_last) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### src/twr_dpath.sv
// ----------------------------------------------------------------------------
// twr_dpath
// Bitmap datapath: operand counters, marking RAM, gap tracking, result regs.
// ----------------------------------------------------------------------------
module twr_dpath #(
   parameter int unsigned WIDTH = twr_pkg::WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  twr_pkg::cmd_type             cmd,
   output twr_pkg::status_type          status,
   input  logic                         req_func,
   input  logic [twr_pkg::FIELD_W-1:0]  req_a_lower,
   input  logic [twr_pkg::FIELD_W-1:0]  req_a_upper,
   input  logic                         req_a_empty,
   input  logic [twr_pkg::FIELD_W-1:0]  req_b_lower,
   input  logic [twr_pkg::FIELD_W-1:0]  req_b_upper,
   input  logic                         req_b_empty,
   output logic [twr_pkg::FIELD_W-1:0]  rsp_r_lower,
   output logic [twr_pkg::FIELD_W-1:0]  rsp_r_upper,
   output logic [1:0]                   rsp_r_kind
);
   import twr_pkg::*;

   localparam int unsigned   DEPTH   = 2 ** WIDTH;
   localparam logic [WIDTH:0] DEPTH_W = DEPTH[WIDTH:0];
   localparam logic [WIDTH-1:0] MASK  = '1;

   // operand walk
   logic             func_ff, func_in;
   logic [WIDTH-1:0] x_ff, x_in, y_ff, y_in, b_lo_ff, b_lo_in;
   logic [WIDTH-1:0] ci_ff, ci_in, cj_ff, cj_in;
   logic [WIDTH-1:0] na_m1_ff, na_m1_in, nb_m1_ff, nb_m1_in;
   logic [WIDTH-1:0] sweep_ff, sweep_in;

   // scan pipeline and gap tracking
   logic             rd_valid_ff, rd_valid_in;
   logic [WIDTH-1:0] rd_idx_ff, rd_idx_in;
   logic             in_gap_ff, in_gap_in, found_ff, found_in, any_zero_ff, any_zero_in;
   logic [WIDTH-1:0] start_ff, start_in, best_start_ff, best_start_in;
   logic [WIDTH:0]   best_len_ff, best_len_in;
   logic [WIDTH-1:0] bottom_ff, bottom_in, top_ff, top_in;

   // result
   logic [WIDTH-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [1:0]       kind_ff, kind_in;

   // RAM port
   logic             ram_we, ram_wd, ram_rd;
   logic [WIDTH-1:0] ram_waddr;

   twr_ram #(
      .DATA_W (1),
      .DEPTH  (DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wd),
      .rd_addr (sweep_ff),
      .rd_data (ram_rd)
   );

   assign status.sweep_last = (sweep_ff == MASK);
   assign status.mark_last  = (ci_ff == na_m1_ff) && (cj_ff == nb_m1_ff);

   always_comb begin
      ram_we    = cmd.clear | cmd.mark;
      ram_wd    = cmd.mark;
      ram_waddr = cmd.mark ? (func_ff ? (x_ff | y_ff) : (x_ff & y_ff)) : sweep_ff;
   end

   always_comb begin
      logic [WIDTH-1:0] a_lo, a_hi, b_lo, b_hi, run_len;
      logic [WIDTH-1:0] fs;
      logic [WIDTH:0]   fl, tail_len;
      logic [WIDTH+1:0] outer;

      func_in       = func_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      b_lo_in       = b_lo_ff;
      ci_in         = ci_ff;
      cj_in         = cj_ff;
      na_m1_in      = na_m1_ff;
      nb_m1_in      = nb_m1_ff;
      sweep_in      = sweep_ff;
      rd_valid_in   = cmd.scan;
      rd_idx_in     = sweep_ff;
      in_gap_in     = in_gap_ff;
      found_in      = found_ff;
      any_zero_in   = any_zero_ff;
      start_in      = start_ff;
      best_start_in = best_start_ff;
      best_len_in   = best_len_ff;
      bottom_in     = bottom_ff;
      top_in        = top_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      kind_in       = kind_ff;

      a_lo     = WIDTH'(req_a_lower);
      a_hi     = WIDTH'(req_a_upper);
      b_lo     = WIDTH'(req_b_lower);
      b_hi     = WIDTH'(req_b_upper);
      run_len  = rd_idx_ff - start_ff;
      fs       = best_start_ff;
      fl       = best_len_ff;
      tail_len = DEPTH_W - {1'b0, start_ff};
      outer    = '0;

      if (cmd.load) begin
         func_in       = req_func;
         x_in          = a_lo;
         y_in          = b_lo;
         b_lo_in       = b_lo;
         ci_in         = '0;
         cj_in         = '0;
         // count minus one; equal bounds give the full span
         na_m1_in      = a_hi - a_lo - 1'b1;
         nb_m1_in      = b_hi - b_lo - 1'b1;
         sweep_in      = '0;
         in_gap_in     = 1'b0;
         found_in      = 1'b0;
         any_zero_in   = 1'b0;
         start_in      = '0;
         best_start_in = '0;
         best_len_in   = '0;
         bottom_in     = '0;
         top_in        = '0;
         lo_in         = '0;
         hi_in         = '0;
         kind_in       = (req_a_empty | req_b_empty) ? KIND_EMPTY : KIND_RANGE;
      end

      if (cmd.clear | cmd.scan) begin
         sweep_in = sweep_ff + 1'b1;
      end

      if (cmd.mark) begin
         if (cj_ff == nb_m1_ff) begin
            cj_in = '0;
            y_in  = b_lo_ff;
            ci_in = ci_ff + 1'b1;
            x_in  = x_ff + 1'b1;
         end else begin
            cj_in = cj_ff + 1'b1;
            y_in  = y_ff + 1'b1;
         end
      end

      if (rd_valid_ff) begin
         if (ram_rd) begin
            top_in = rd_idx_ff;
            if (!found_ff) begin
               found_in  = 1'b1;
               bottom_in = rd_idx_ff;
            end
            if (in_gap_ff) begin
               in_gap_in = 1'b0;
               if ({1'b0, run_len} > best_len_ff) begin
                  best_start_in = start_ff;
                  best_len_in   = {1'b0, run_len};
               end
            end
         end else begin
            any_zero_in = 1'b1;
            if (!in_gap_ff) begin
               in_gap_in = 1'b1;
               start_in  = rd_idx_ff;
            end
         end
      end

      if (cmd.finish) begin
         // a run that reaches the top counts as its own gap
         if (in_gap_ff && (tail_len > best_len_ff)) begin
            fs = start_ff;
            fl = tail_len;
         end
         outer = {2'b00, bottom_ff} + {2'b00, MASK - top_ff};
         if (!any_zero_ff) begin
            kind_in = KIND_FULL;
            lo_in   = MASK;
            hi_in   = MASK;
         end else begin
            kind_in = KIND_RANGE;
            if (outer > {1'b0, fl}) begin
               lo_in = bottom_ff;
               hi_in = top_ff + 1'b1;
            end else begin
               lo_in = fs + fl[WIDTH-1:0];
               hi_in = fs;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      b_lo_ff       <= b_lo_in;
      ci_ff         <= ci_in;
      cj_ff         <= cj_in;
      na_m1_ff      <= na_m1_in;
      nb_m1_ff      <= nb_m1_in;
      sweep_ff      <= sweep_in;
      rd_idx_ff     <= rd_idx_in;
      in_gap_ff     <= in_gap_in;
      found_ff      <= found_in;
      any_zero_ff   <= any_zero_in;
      start_ff      <= start_in;
      best_start_ff <= best_start_in;
      best_len_ff   <= best_len_in;
      bottom_ff     <= bottom_in;
      top_ff        <= top_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      kind_ff       <= kind_in;
   end

   assign rsp_r_lower = FIELD_W'(lo_ff);
   assign rsp_r_upper = FIELD_W'(hi_ff);
   assign rsp_r_kind  = kind_ff;

endmodule

### src/tightest_wrapped_range_of_and_or.sv
// ----------------------------------------------------------------------------
// tightest_wrapped_range_of_and_or
// Smallest wrapped range covering a bitwise AND/OR of two wrapped ranges.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): two half-open wrapped ranges [lower, upper) plus
//   empty flags, and req_func (0 AND, 1 OR). Equal bounds mean the full set.
//   Response channel (rsp_*): r_lower, r_upper and r_kind (range/empty/full).
//   One response per request, in order. One request in flight at a time;
//   req_ready is high only while the unit is idle.
// Sequence (accept to rsp_valid):
//   either range empty        : idle goes straight to done
//   otherwise                 : clear, mark, scan, drain, finish, done
//   The 2^WIDTH-entry bitmap RAM is the bottleneck: one clear sweep, one
//   write per operand pair (na*nb writes, where na, nb are the range sizes),
//   one read sweep, each at one RAM access per cycle.
//   After the response is taken, the next request is taken in idle.
// Reset: synchronous, active high; returns to idle with no response pending.
//   The bitmap holds no reset state; every non-empty request clears it first.
// Stall: the response is held, stable, until rsp_ready; no new request is
//   taken meanwhile.
// ----------------------------------------------------------------------------
module tightest_wrapped_range_of_and_or #(
   parameter int unsigned WIDTH = twr_pkg::WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_func,
   input  logic [twr_pkg::FIELD_W-1:0]  req_a_lower,
   input  logic [twr_pkg::FIELD_W-1:0]  req_a_upper,
   input  logic                         req_a_empty,
   input  logic [twr_pkg::FIELD_W-1:0]  req_b_lower,
   input  logic [twr_pkg::FIELD_W-1:0]  req_b_upper,
   input  logic                         req_b_empty,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [twr_pkg::FIELD_W-1:0]  rsp_r_lower,
   output logic [twr_pkg::FIELD_W-1:0]  rsp_r_upper,
   output logic [1:0]                   rsp_r_kind
);
   import twr_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: idle -> clear -> mark -> scan -> drain -> finish -> done (idle -> done if a range is empty)
   twr_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_is_empty (req_a_empty | req_b_empty),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .cmd          (cmd),
      .status       (status)
   );

   // bitmap, operand counters and gap tracking
   twr_dpath #(
      .WIDTH (WIDTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_func    (req_func),
      .req_a_lower (req_a_lower),
      .req_a_upper (req_a_upper),
      .req_a_empty (req_a_empty),
      .req_b_lower (req_b_lower),
      .req_b_upper (req_b_upper),
      .req_b_empty (req_b_empty),
      .rsp_r_lower (rsp_r_lower),
      .rsp_r_upper (rsp_r_upper),
      .rsp_r_kind  (rsp_r_kind)
   );

endmodule
